FILE: sv/wfl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wfl_pkg;

  // Field and storage widths
  localparam int COMP_W   = 32;
  localparam int NCOMP_MAX = 4;
  localparam int NFAM_MAX = 4;
  localparam int IDX_W    = 2;
  localparam int FAM_W    = 2;
  localparam int MODE_W   = 3;
  localparam int ADDR_W   = 4;
  localparam int R_W      = 31;
  localparam int FAC_W    = 18;
  localparam int ACC_W    = 64;
  localparam int STEP_W   = 5;

  // Limiter codes
  localparam logic [MODE_W-1:0] MODE_OFF      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MINMOD   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SUPERBEE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_VANLEER  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MC       = 3'd4;
  localparam logic [MODE_W-1:0] MODE_BW       = 3'd5;

  // Q15.16 / Q2.16 constants
  localparam logic [31:0] QONE = 32'd65536;
  localparam logic [31:0] QTWO = 32'd131072;
  localparam logic [R_W-1:0] R_SAT = '1;

  // Divider step counts: ratio has 31 quotient bits, van Leer 17
  localparam logic [STEP_W-1:0] RATIO_STEPS = 5'd31;
  localparam logic [STEP_W-1:0] VL_STEPS    = 5'd17;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_PASSH,
    ST_DOT,
    ST_DRAIN,
    ST_FAC,
    ST_DIV1,
    ST_RSEL,
    ST_DIV2,
    ST_SCALE,
    ST_SDRAIN,
    ST_EMITL,
    ST_TAIL
  } state_t;

  typedef enum logic [1:0] {
    SEL_DR,
    SEL_NM,
    SEL_SCALE
  } mac_sel_t;

  typedef struct packed {
    logic             issue;
    logic             clear;
    mac_sel_t         sel;
    logic [IDX_W-1:0] idx;
  } mac_req_t;

  typedef struct packed {
    logic             valid;
    mac_sel_t         sel;
    logic [IDX_W-1:0] idx;
  } mac_rsp_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage
`default_nettype wire

FILE: sv/wfl_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Cell word channel
interface wfl_cell_if;
  import wfl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [COMP_W-1:0] comp_0;
  logic signed [COMP_W-1:0] comp_1;
  logic signed [COMP_W-1:0] comp_2;
  logic signed [COMP_W-1:0] comp_3;
  logic                     speed_positive;
  logic [FAM_W-1:0]         wave_family;
  logic                     first_cell;
  logic                     last_cell;

  modport source (output valid, comp_0, comp_1, comp_2, comp_3, speed_positive,
                  wave_family, first_cell, last_cell, input ready);
  modport sink (input valid, comp_0, comp_1, comp_2, comp_3, speed_positive,
                wave_family, first_cell, last_cell, output ready);
endinterface

// Limited result word channel
interface wfl_res_if;
  import wfl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [COMP_W-1:0] out_comp_0;
  logic signed [COMP_W-1:0] out_comp_1;
  logic signed [COMP_W-1:0] out_comp_2;
  logic signed [COMP_W-1:0] out_comp_3;
  logic [FAM_W-1:0]         out_family;
  logic                     row_end;

  modport source (output valid, out_comp_0, out_comp_1, out_comp_2, out_comp_3,
                  out_family, row_end, input ready);
  modport sink (input valid, out_comp_0, out_comp_1, out_comp_2, out_comp_3,
                out_family, row_end, output ready);
endinterface
`default_nettype wire

FILE: sv/wave_flux_limiter.sv
`timescale 1ns / 1ps
`default_nettype none
// Wave limiter: takes one cell word at a time and returns zero, one or two
// result words. A cell is accepted only when the sequencer is idle. A cell
// that finds no held cell goes from its check step straight to its tail
// step; a first cell that finds one flushes the open row first. A limited
// cell runs 2*COMPONENTS dot/norm products through one 33x33 multiplier,
// then a bit-serial divider for r, run again for van Leer, then COMPONENTS
// scaling products; the division for r is skipped when the factor needs no
// division or r saturates. A result word that is not taken holds the
// sequencer at its emit step; once the last result of a cell sits in the
// output register the next cell is let in.
// Limiter codes sit at APB byte addresses 0, 4, 8 and 12, one per family.
module wave_flux_limiter #(
  parameter int COMPONENTS = 4,
  parameter int FAMILIES   = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  wfl_cell_if.sink                   cells,
  wfl_res_if.source                  limited,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wfl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import wfl_pkg::*;

  logic [MODE_W-1:0]        limit_mode [NFAM_MAX];
  logic signed [COMP_W-1:0] held [NCOMP_MAX];
  logic signed [COMP_W-1:0] x [NCOMP_MAX];
  logic signed [COMP_W-1:0] res [NCOMP_MAX];
  logic signed [COMP_W-1:0] oc [NCOMP_MAX];
  logic signed [COMP_W-1:0] e_comp [NCOMP_MAX];
  logic                     held_sp, held_first, held_valid;
  logic [FAM_W-1:0]         held_fam;
  logic signed [ACC_W-1:0]  left_dot;
  logic                     x_sp, x_first, x_last, had;
  logic [FAM_W-1:0]         x_fam;
  state_t                   state, state_next;
  logic [IDX_W-1:0]         idx;
  logic                     phase;
  logic [R_W-1:0]           r_q;
  logic [FAC_W-1:0]         fac;
  logic                     ovalid, oend;
  logic [FAM_W-1:0]         ofam;
  logic                     out_free, emit, e_end;
  logic [FAM_W-1:0]         e_fam;
  logic                     fac_load, r_load;
  logic [FAC_W-1:0]         fac_val, fsel;
  logic [R_W-1:0]           r_val;
  logic [MODE_W-1:0]        mode_cur;
  logic                     mode_bypass;
  logic signed [ACC_W-1:0]  d_sel;
  logic [ACC_W-1:0]         d_u;
  logic                     last_idx;
  mac_req_t                 mreq;
  mac_rsp_t                 mrsp;
  logic signed [32:0]       ma, mb;
  logic signed [65:0]       prod;
  logic signed [ACC_W-1:0]  acc_dr, acc_nm;
  logic signed [65:0]       sh;
  logic signed [COMP_W-1:0] scaled;
  div_req_t                 dreq;
  logic [63:0]              d_rem, d_dvs;
  logic [30:0]              d_low;
  logic                     d_done;
  logic [30:0]              d_quot;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = {29'b0, limit_mode[paddr[ADDR_W-1:2]]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NFAM_MAX; i++) limit_mode[i] <= MODE_OFF;
    end else if (psel && penable && pwrite) begin
      limit_mode[paddr[ADDR_W-1:2]] <= pwdata[MODE_W-1:0];
    end
  end

  // Shared units
  wfl_mac u_mac (
    .clk(clk), .rst(rst), .req(mreq), .a(ma), .b(mb),
    .rsp(mrsp), .prod(prod), .acc_dr(acc_dr), .acc_nm(acc_nm)
  );

  wfl_div u_div (
    .clk(clk), .rst(rst), .req(dreq), .rem_init(d_rem), .divisor(d_dvs),
    .low_bits(d_low), .done(d_done), .quot(d_quot)
  );

  // Mode of the held cell and the upwind dot
  always_comb begin
    if ({1'b0, held_fam} < 3'(FAMILIES)) mode_cur = limit_mode[held_fam];
    else mode_cur = MODE_OFF;
    mode_bypass = (mode_cur == MODE_OFF) || (mode_cur > MODE_BW);
    d_sel = held_sp ? left_dot : acc_dr;
    d_u   = d_sel;
  end

  // Limiter factor from r
  always_comb begin
    logic [31:0] r32, r2, lo, hi, h;
    hi  = '0;
    r32 = {1'b0, r_q};
    r2  = {r_q, 1'b0};
    h   = 32'((33'(r32) + 33'(QONE)) >> 1);
    case (mode_cur)
      MODE_MINMOD: lo = (r32 < QONE) ? r32 : QONE;
      MODE_SUPERBEE: begin
        lo = (r2 < QONE) ? r2 : QONE;
        hi = (r32 < QTWO) ? r32 : QTWO;
        lo = (lo > hi) ? lo : hi;
      end
      MODE_MC: begin
        lo = (h < QTWO) ? h : QTWO;
        lo = (lo < r2) ? lo : r2;
      end
      default: lo = (r32 < QTWO) ? r32 : QTWO;
    endcase
    fsel = lo[FAC_W-1:0];
  end

  // Scaled component, saturated to 32 bits
  always_comb begin
    sh = prod >>> 16;
    if (!sh[65] && (|sh[64:31]))      scaled = 32'sh7FFF_FFFF;
    else if (sh[65] && !(&sh[64:31])) scaled = 32'sh8000_0000;
    else                              scaled = sh[31:0];
  end

  // Multiplier operands
  always_comb begin
    last_idx = idx == IDX_W'(COMPONENTS - 1);
    ma = {held[idx][COMP_W-1], held[idx]};
    if (state == ST_SCALE) mb = {15'b0, fac};
    else if (phase)        mb = {held[idx][COMP_W-1], held[idx]};
    else                   mb = {x[idx][COMP_W-1], x[idx]};
    mreq.issue = (state == ST_DOT) || (state == ST_SCALE);
    mreq.clear = state == ST_CHK;
    mreq.idx   = idx;
    if (state == ST_SCALE) mreq.sel = SEL_SCALE;
    else if (phase)        mreq.sel = SEL_NM;
    else                   mreq.sel = SEL_DR;
  end

  // Divider operands: ratio in ST_FAC, van Leer otherwise
  always_comb begin
    if (state == ST_FAC) begin
      d_rem = d_u >> 15;
      d_dvs = acc_nm;
      d_low = {d_u[14:0], 16'b0};
    end else begin
      d_rem = 64'(r_q);
      d_dvs = 64'(r_q) + 64'(QONE);
      d_low = '0;
    end
  end

  assign out_free = !ovalid || limited.ready;
  assign cells.ready = state == ST_IDLE;

  // Sequencer: next state, emits, factor loads
  always_comb begin
    state_next = state;
    emit       = 1'b0;
    e_fam      = held_fam;
    e_end      = 1'b1;
    fac_load   = 1'b0;
    fac_val    = '0;
    r_load     = 1'b0;
    r_val      = d_quot;
    dreq.start = 1'b0;
    dreq.steps = (state == ST_FAC) ? RATIO_STEPS : VL_STEPS;
    for (int m = 0; m < NCOMP_MAX; m++) e_comp[m] = (m < COMPONENTS) ? held[m] : '0;
    case (state)
      ST_IDLE: if (cells.valid) state_next = ST_CHK;
      ST_CHK: begin
        if (x_first && held_valid) state_next = ST_PASSH;
        else if (held_valid)       state_next = ST_DOT;
        else                       state_next = ST_TAIL;
      end
      ST_PASSH: begin
        emit = out_free;
        if (out_free) state_next = ST_TAIL;
      end
      ST_DOT: if (last_idx && phase) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_FAC;
      ST_FAC: begin
        if (held_first || acc_nm == '0 || mode_bypass) begin
          fac_load = 1'b1;
          fac_val  = QONE[FAC_W-1:0];
          state_next = ST_SCALE;
        end else if (d_sel[ACC_W-1] || d_sel == '0) begin
          fac_load = 1'b1;
          state_next = ST_SCALE;
        end else if ((d_u >> 15) >= acc_nm) begin
          r_load = 1'b1;
          r_val  = R_SAT;
          state_next = ST_RSEL;
        end else begin
          dreq.start = 1'b1;
          state_next = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (d_done) begin
          r_load = 1'b1;
          state_next = ST_RSEL;
        end
      end
      ST_RSEL: begin
        if (mode_cur == MODE_VANLEER) begin
          dreq.start = 1'b1;
          state_next = ST_DIV2;
        end else begin
          fac_load = 1'b1;
          fac_val  = fsel;
          state_next = ST_SCALE;
        end
      end
      ST_DIV2: begin
        if (d_done) begin
          fac_load = 1'b1;
          fac_val  = d_quot[FAC_W-1:0];
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: if (last_idx) state_next = ST_SDRAIN;
      ST_SDRAIN: state_next = ST_EMITL;
      ST_EMITL: begin
        emit  = out_free;
        e_end = 1'b0;
        for (int m = 0; m < NCOMP_MAX; m++) e_comp[m] = (m < COMPONENTS) ? res[m] : '0;
        if (out_free) state_next = ST_TAIL;
      end
      ST_TAIL: begin
        e_fam = x_fam;
        for (int m = 0; m < NCOMP_MAX; m++) e_comp[m] = (m < COMPONENTS) ? x[m] : '0;
        if (x_last) begin
          emit = out_free;
          if (out_free) state_next = ST_IDLE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Held cell and row bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_first <= 1'b0;
      held_sp    <= 1'b0;
      held_fam   <= '0;
      left_dot   <= '0;
      had        <= 1'b0;
      idx        <= '0;
      phase      <= 1'b0;
    end else begin
      if (state == ST_DOT || state == ST_SCALE) begin
        idx <= last_idx ? '0 : idx + 1'b1;
        if (last_idx) phase <= ~phase;
      end else begin
        idx   <= '0;
        phase <= 1'b0;
      end
      case (state)
        ST_IDLE: if (cells.valid) had <= 1'b0;
        ST_PASSH: if (out_free) held_valid <= 1'b0;
        ST_EMITL: begin
          if (out_free) begin
            left_dot   <= acc_dr;
            held_valid <= 1'b0;
            had        <= 1'b1;
          end
        end
        ST_TAIL: begin
          if (x_last) begin
            if (out_free) left_dot <= '0;
          end else begin
            held_sp    <= x_sp;
            held_fam   <= x_fam;
            held_first <= x_first || !had;
            held_valid <= 1'b1;
            if (x_first || !had) left_dot <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cells.valid) begin
      x[0]    <= cells.comp_0;
      x[1]    <= cells.comp_1;
      x[2]    <= cells.comp_2;
      x[3]    <= cells.comp_3;
      x_sp    <= cells.speed_positive;
      x_fam   <= cells.wave_family;
      x_first <= cells.first_cell;
      x_last  <= cells.last_cell;
    end
    if (state == ST_TAIL && !x_last) begin
      for (int m = 0; m < NCOMP_MAX; m++) held[m] <= x[m];
    end
    if (r_load) r_q <= r_val;
    if (fac_load) fac <= fac_val;
    if (mrsp.valid && mrsp.sel == SEL_SCALE) res[mrsp.idx] <= scaled;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (emit) begin
      ovalid <= 1'b1;
    end else if (limited.ready) begin
      ovalid <= 1'b0;
    end
    if (emit) begin
      for (int m = 0; m < NCOMP_MAX; m++) oc[m] <= e_comp[m];
      ofam <= e_fam;
      oend <= e_end;
    end
  end

  assign limited.valid      = ovalid;
  assign limited.out_comp_0 = oc[0];
  assign limited.out_comp_1 = oc[1];
  assign limited.out_comp_2 = oc[2];
  assign limited.out_comp_3 = oc[3];
  assign limited.out_family = ofam;
  assign limited.row_end    = oend;
endmodule
`default_nettype wire

FILE: sv/wfl_mac.sv
`timescale 1ns / 1ps
`default_nettype none
module wfl_mac (
  input  logic                     clk,
  input  logic                     rst,
  input  wfl_pkg::mac_req_t        req,
  input  logic signed [32:0]       a,
  input  logic signed [32:0]       b,
  output wfl_pkg::mac_rsp_t        rsp,
  output logic signed [65:0]       prod,
  output logic signed [63:0]       acc_dr,
  output logic signed [63:0]       acc_nm
);
  import wfl_pkg::*;

  // Product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else begin
      rsp.valid <= req.issue;
    end
    rsp.sel <= req.sel;
    rsp.idx <= req.idx;
    prod    <= a * b;
  end

  // Accumulate floor(product / 4) into dot or norm
  always_ff @(posedge clk) begin
    if (req.clear) begin
      acc_dr <= '0;
      acc_nm <= '0;
    end else if (rsp.valid) begin
      case (rsp.sel)
        SEL_DR:  acc_dr <= acc_dr + signed'(prod[65:2]);
        SEL_NM:  acc_nm <= acc_nm + signed'(prod[65:2]);
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/wfl_div.sv
`timescale 1ns / 1ps
`default_nettype none
module wfl_div (
  input  logic               clk,
  input  logic               rst,
  input  wfl_pkg::div_req_t  req,
  input  logic [63:0]        rem_init,
  input  logic [63:0]        divisor,
  input  logic [30:0]        low_bits,
  output logic               done,
  output logic [30:0]        quot
);
  import wfl_pkg::*;

  logic [63:0]       rem;
  logic [63:0]       dvs;
  logic [30:0]       bits;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic [64:0]       trial;
  logic [64:0]       diff;
  logic              ge;

  // One quotient bit per cycle, restoring
  always_comb begin
    trial = {rem, bits[30]};
    diff  = trial - {1'b0, dvs};
    ge    = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= rem_init;
      dvs  <= divisor;
      bits <= low_bits;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[63:0] : trial[63:0];
      bits <= {bits[29:0], 1'b0};
      quot <= {quot[29:0], ge};
    end
  end
endmodule
`default_nettype wire

FILE: sv/wfl_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module wfl_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       cells_valid,
  input logic                       cells_ready,
  input logic                       lim_valid,
  input logic                       lim_ready,
  input logic [31:0]                lim_comp_0,
  input logic                       lim_row_end,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [wfl_pkg::ADDR_W-1:0] paddr,
  input logic [31:0]                pwdata,
  input logic [31:0]                prdata
);
  import wfl_pkg::*;

  // No result word right after reset
  a_rst_idle: assert property (@(posedge clk) rst |=> !lim_valid)
    else $error("result word valid after reset");

  // A stalled result word stays valid with comp_0 and row_end stable
  a_hold: assert property (@(posedge clk) disable iff (rst)
    lim_valid && !lim_ready |=> lim_valid && $stable(lim_comp_0) && $stable(lim_row_end))
    else $error("stalled result word changed");

  // One cell word in flight: ready drops after each accept
  a_one_cell: assert property (@(posedge clk) disable iff (rst)
    cells_valid && cells_ready |=> !cells_ready)
    else $error("cell word taken while busy");

  // A written limiter code reads back
  a_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite |=>
      (paddr != $past(paddr)) || (prdata[MODE_W-1:0] == $past(pwdata[MODE_W-1:0])))
    else $error("limiter code read-back mismatch");
endmodule

bind wave_flux_limiter wfl_chk u_wfl_chk (
  .clk(clk), .rst(rst),
  .cells_valid(cells.valid), .cells_ready(cells.ready),
  .lim_valid(limited.valid), .lim_ready(limited.ready),
  .lim_comp_0(limited.out_comp_0), .lim_row_end(limited.row_end),
  .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
  .pwdata(pwdata), .prdata(prdata)
);
`default_nettype wire
